[rtl/tagged_bit_stream_packer_top_assert.svh]
// assertion macros for the tagged bit stream packer
// used by tbsp_seq; no other dependencies
`ifndef TAGGED_BIT_STREAM_PACKER_TOP_ASSERT_SVH
`define TAGGED_BIT_STREAM_PACKER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// condition holds at every edge out of reset
`define TBSP_ASSERT_HOLDS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// condition implies consequence in the same cycle
`define TBSP_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// condition implies consequence in the next cycle
`define TBSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TBSP_ASSERT_HOLDS(label, clk, rst, cond, msg)
`define TBSP_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define TBSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

[rtl/tbsp_pkg.sv]
// shared types and constants for the tagged bit stream packer
// no dependencies
`timescale 1ns / 1ps

package tbsp_pkg;

   localparam int DEFAULT_CAPACITY_BYTES = 256;
   localparam int TAG_BITS = 5;
   localparam int STREAM_W = 32 + TAG_BITS;

   localparam logic [4:0] TAG_BOOL = 5'd1;
   localparam logic [4:0] TAG_S32  = 5'd7;
   localparam logic [4:0] TAG_U32  = 5'd8;
   localparam logic [5:0] RAW_MAX_BITS = 6'd32;

   typedef enum logic [2:0] {
      OP_START      = 3'd0,
      OP_WRITE_RAW  = 3'd1,
      OP_READ_RAW   = 3'd2,
      OP_WRITE_BOOL = 3'd3,
      OP_WRITE_S32  = 3'd4,
      OP_WRITE_U32  = 3'd5,
      OP_READ_BOOL  = 3'd6,
      OP_READ_U32   = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      STAT_OK           = 3'd0,
      STAT_ZERO_COUNT   = 3'd1,
      STAT_PAST_LIMIT   = 3'd2,
      STAT_TAG_MISMATCH = 3'd3,
      STAT_CAPACITY     = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_DECODE,
      SEQ_FETCH,
      SEQ_BYTE,
      SEQ_FINISH
   } seq_state_type;

   typedef struct packed {
      op_type      opcode;
      logic [5:0]  bit_count;
      logic [31:0] write_value;
      logic [8:0]  length_bytes;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] read_value;
      logic [8:0]  used_bytes;
      logic [11:0] cursor_bit;
   } rsp_type;

endpackage

[rtl/tbsp_store.sv]
// byte store: one write port, one read port with registered read data
// no package dependencies
`timescale 1ns / 1ps

module tbsp_store #(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/tbsp_lane.sv]
// shared byte unit: merges a bit field into a byte and extracts it
// no package dependencies
`timescale 1ns / 1ps

module tbsp_lane (
   input  logic [7:0] old_byte,
   input  logic [7:0] src_bits,
   input  logic [2:0] offset,
   input  logic [3:0] take,
   output logic [7:0] new_byte,
   output logic [7:0] got_bits
);

   logic [8:0] span_mask;
   logic [7:0] take_mask;
   logic [7:0] field_mask;

   // take is 1..8 and offset + take never passes 8
   assign span_mask  = (9'd1 << take) - 9'd1;
   assign take_mask  = span_mask[7:0];
   assign field_mask = take_mask << offset;
   assign new_byte   = (old_byte & ~field_mask) | ((src_bits << offset) & field_mask);
   assign got_bits   = (old_byte >> offset) & take_mask;

endmodule

[rtl/tbsp_seq.sv]
// sequencer: decodes an item, walks the store one byte per cycle, builds the result
// depends on tbsp_pkg, tbsp_lane and the assertion macro header
`timescale 1ns / 1ps
`include "tagged_bit_stream_packer_top_assert.svh"

module tbsp_seq #(
   parameter int CAPACITY_BYTES = tbsp_pkg::DEFAULT_CAPACITY_BYTES,
   parameter int ADDR_W = $clog2(CAPACITY_BYTES)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              use_type_tags,
   input  logic              req_valid,
   output logic              req_ready,
   input  tbsp_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tbsp_pkg::rsp_type rsp_payload,
   output logic              mem_rd_en,
   output logic [ADDR_W-1:0] mem_rd_addr,
   input  logic [7:0]        mem_rd_data,
   output logic              mem_wr_en,
   output logic [ADDR_W-1:0] mem_wr_addr,
   output logic [7:0]        mem_wr_data
);

   localparam int CAP_BITS = CAPACITY_BYTES * 8;
   localparam int CUR_W    = $clog2(CAP_BITS + 1);
   localparam int SW       = tbsp_pkg::STREAM_W;

   tbsp_pkg::seq_state_type state_ff, state_in;
   tbsp_pkg::req_type       req_ff, req_in;
   logic [CUR_W-1:0]        cursor_ff, cursor_in;
   logic [CUR_W-1:0]        limit_ff, limit_in;
   logic [CUR_W-1:0]        pos_ff, pos_in;
   logic [5:0]              remain_ff, remain_in;
   logic [5:0]              done_ff, done_in;
   logic [SW-1:0]           sr_ff, sr_in;
   logic [SW-1:0]           acc_ff, acc_in;
   tbsp_pkg::status_type    status_ff, status_in;
   logic                    is_write_ff, is_write_in;
   logic                    tag_check_ff, tag_check_in;
   logic [4:0]              exp_tag_ff, exp_tag_in;
   logic                    val_shift_ff, val_shift_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   tbsp_pkg::rsp_type       rsp_ff, rsp_in;

   // decode
   logic [5:0]       cnt_sat;
   logic [5:0]       val_bits;
   logic [5:0]       total_bits;
   logic             tag_used;
   logic [4:0]       tag_code;
   logic [31:0]      wdata;
   logic             is_wr;
   logic             is_rd;
   logic [SW-1:0]    stream;
   logic [CUR_W:0]   end_sum;
   logic [CUR_W:0]   tag_end;
   logic             cap_fail;
   logic             lim_fail;
   logic             tag_fail;
   logic [CUR_W-1:0] start_limit;

   // byte walk
   logic [ADDR_W-1:0] pos_addr;
   logic [3:0]        room;
   logic [3:0]        take;
   logic [7:0]        new_byte;
   logic [7:0]        got_bits;

   // finish
   logic                 tag_bad;
   tbsp_pkg::status_type fin_status;
   logic [CUR_W-1:0]     fin_cursor;
   logic [31:0]          fin_value;
   logic [31:0]          fin_cur_wide;
   logic [31:0]          fin_used_wide;

   tbsp_lane u_lane (
      .old_byte (mem_rd_data),
      .src_bits (sr_ff[7:0]),
      .offset   (pos_ff[2:0]),
      .take     (take),
      .new_byte (new_byte),
      .got_bits (got_bits)
   );

   assign pos_addr = pos_ff[ADDR_W+2:3];
   assign room     = 4'd8 - {1'b0, pos_ff[2:0]};
   assign take     = (remain_ff < {2'b00, room}) ? remain_ff[3:0] : room;

   always_comb begin
      cnt_sat  = (req_ff.bit_count > tbsp_pkg::RAW_MAX_BITS) ? tbsp_pkg::RAW_MAX_BITS
                                                            : req_ff.bit_count;
      val_bits = '0;
      tag_used = 1'b0;
      tag_code = '0;
      wdata    = req_ff.write_value;
      is_wr    = 1'b0;
      is_rd    = 1'b0;
      case (req_ff.opcode)
         tbsp_pkg::OP_WRITE_RAW: begin
            val_bits = cnt_sat;
            is_wr    = 1'b1;
         end
         tbsp_pkg::OP_READ_RAW: begin
            val_bits = cnt_sat;
            is_rd    = 1'b1;
         end
         tbsp_pkg::OP_WRITE_BOOL: begin
            val_bits = 6'd1;
            tag_used = use_type_tags;
            tag_code = tbsp_pkg::TAG_BOOL;
            wdata    = {31'd0, |req_ff.write_value};
            is_wr    = 1'b1;
         end
         tbsp_pkg::OP_WRITE_S32: begin
            val_bits = 6'd32;
            tag_used = use_type_tags;
            tag_code = tbsp_pkg::TAG_S32;
            is_wr    = 1'b1;
         end
         tbsp_pkg::OP_WRITE_U32: begin
            val_bits = 6'd32;
            tag_used = use_type_tags;
            tag_code = tbsp_pkg::TAG_U32;
            is_wr    = 1'b1;
         end
         tbsp_pkg::OP_READ_BOOL: begin
            val_bits = 6'd1;
            tag_used = use_type_tags;
            tag_code = tbsp_pkg::TAG_BOOL;
            is_rd    = 1'b1;
         end
         tbsp_pkg::OP_READ_U32: begin
            val_bits = 6'd32;
            tag_used = use_type_tags;
            tag_code = tbsp_pkg::TAG_U32;
            is_rd    = 1'b1;
         end
         default: begin
         end
      endcase
      total_bits = val_bits + (tag_used ? 6'(tbsp_pkg::TAG_BITS) : 6'd0);
      stream     = tag_used ? {wdata, tag_code} : {5'd0, wdata};
      end_sum    = {1'b0, cursor_ff} + (CUR_W+1)'(total_bits);
      tag_end    = {1'b0, cursor_ff} + (CUR_W+1)'(tbsp_pkg::TAG_BITS);
      cap_fail   = end_sum > (CUR_W+1)'(CAP_BITS);
      lim_fail   = end_sum > {1'b0, limit_ff};
      tag_fail   = tag_end > {1'b0, limit_ff};
      if (32'(req_ff.length_bytes) > 32'(CAPACITY_BYTES)) begin
         start_limit = CUR_W'(CAP_BITS);
      end else begin
         start_limit = CUR_W'({req_ff.length_bytes, 3'b000});
      end
   end

   always_comb begin
      tag_bad       = tag_check_ff && (acc_ff[4:0] != exp_tag_ff);
      fin_status    = tag_bad ? tbsp_pkg::STAT_TAG_MISMATCH : status_ff;
      fin_cursor    = tag_bad ? cursor_ff + CUR_W'(tbsp_pkg::TAG_BITS) : pos_ff;
      fin_value     = val_shift_ff ? acc_ff[SW-1:tbsp_pkg::TAG_BITS] : acc_ff[31:0];
      fin_cur_wide  = 32'(fin_cursor);
      fin_used_wide = (fin_cur_wide + 32'd7) >> 3;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tbsp_pkg::SEQ_IDLE;
         cursor_ff    <= '0;
         limit_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff       <= req_in;
      pos_ff       <= pos_in;
      remain_ff    <= remain_in;
      done_ff      <= done_in;
      sr_ff        <= sr_in;
      acc_ff       <= acc_in;
      status_ff    <= status_in;
      is_write_ff  <= is_write_in;
      tag_check_ff <= tag_check_in;
      exp_tag_ff   <= exp_tag_in;
      val_shift_ff <= val_shift_in;
      rsp_ff       <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      cursor_in    = cursor_ff;
      limit_in     = limit_ff;
      pos_in       = pos_ff;
      remain_in    = remain_ff;
      done_in      = done_ff;
      sr_in        = sr_ff;
      acc_in       = acc_ff;
      status_in    = status_ff;
      is_write_in  = is_write_ff;
      tag_check_in = tag_check_ff;
      exp_tag_in   = exp_tag_ff;
      val_shift_in = val_shift_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_in       = rsp_ff;
      req_ready    = 1'b0;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = pos_addr;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = pos_addr;
      mem_wr_data  = new_byte;
      case (state_ff)
         tbsp_pkg::SEQ_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in   = req_payload;
               state_in = tbsp_pkg::SEQ_DECODE;
            end
         end
         tbsp_pkg::SEQ_DECODE: begin
            pos_in       = cursor_ff;
            done_in      = '0;
            acc_in       = '0;
            sr_in        = stream;
            remain_in    = total_bits;
            status_in    = tbsp_pkg::STAT_OK;
            is_write_in  = is_wr;
            tag_check_in = tag_used & is_rd;
            exp_tag_in   = tag_code;
            val_shift_in = tag_used;
            state_in     = tbsp_pkg::SEQ_FETCH;
            if (!is_wr && !is_rd) begin
               // start: rewind and set the limit together
               pos_in       = '0;
               cursor_in    = '0;
               limit_in     = start_limit;
               is_write_in  = 1'b0;
               tag_check_in = 1'b0;
               state_in     = tbsp_pkg::SEQ_FINISH;
            end else if (val_bits == 6'd0) begin
               status_in    = tbsp_pkg::STAT_ZERO_COUNT;
               is_write_in  = 1'b0;
               tag_check_in = 1'b0;
               state_in     = tbsp_pkg::SEQ_FINISH;
            end else if (is_wr && cap_fail) begin
               status_in    = tbsp_pkg::STAT_CAPACITY;
               is_write_in  = 1'b0;
               state_in     = tbsp_pkg::SEQ_FINISH;
            end else if (is_rd && tag_used && tag_fail) begin
               status_in    = tbsp_pkg::STAT_PAST_LIMIT;
               tag_check_in = 1'b0;
               state_in     = tbsp_pkg::SEQ_FINISH;
            end else if (is_rd && tag_used && lim_fail) begin
               // only the tag fits: consume and check it, value read fails
               remain_in = 6'(tbsp_pkg::TAG_BITS);
               status_in = tbsp_pkg::STAT_PAST_LIMIT;
            end else if (is_rd && lim_fail) begin
               status_in = tbsp_pkg::STAT_PAST_LIMIT;
               state_in  = tbsp_pkg::SEQ_FINISH;
            end
         end
         tbsp_pkg::SEQ_FETCH: begin
            mem_rd_en = 1'b1;
            state_in  = tbsp_pkg::SEQ_BYTE;
         end
         tbsp_pkg::SEQ_BYTE: begin
            mem_wr_en = is_write_ff;
            pos_in    = pos_ff + CUR_W'(take);
            remain_in = remain_ff - 6'(take);
            sr_in     = sr_ff >> take;
            acc_in    = acc_ff | (SW'(got_bits) << done_ff);
            done_in   = done_ff + 6'(take);
            if (remain_ff == 6'(take)) begin
               state_in = tbsp_pkg::SEQ_FINISH;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = pos_addr + ADDR_W'(1);
            end
         end
         tbsp_pkg::SEQ_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in.status = fin_status;
               rsp_in.read_value = (fin_status == tbsp_pkg::STAT_OK && !is_write_ff)
                                   ? fin_value : 32'd0;
               rsp_in.used_bytes = fin_used_wide[8:0];
               rsp_in.cursor_bit = fin_cur_wide[11:0];
               cursor_in = fin_cursor;
               if (is_write_ff && (pos_ff > limit_ff)) begin
                  limit_in = pos_ff;
               end
               state_in = tbsp_pkg::SEQ_IDLE;
            end
         end
         default: begin
            state_in = tbsp_pkg::SEQ_IDLE;
         end
      endcase
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `TBSP_ASSERT_IMPLIES(a_byte_has_work, clock, reset, state_ff == tbsp_pkg::SEQ_BYTE, remain_ff != 6'd0, "byte step with no bits left")
   `TBSP_ASSERT_HOLDS(a_cursor_within_limit, clock, reset, cursor_ff <= limit_ff, "cursor past limit")
   `TBSP_ASSERT_HOLDS(a_limit_within_store, clock, reset, limit_ff <= CUR_W'(CAP_BITS), "limit past store")
   `TBSP_ASSERT_NEXT(a_fetch_then_byte, clock, reset, state_ff == tbsp_pkg::SEQ_FETCH, state_ff == tbsp_pkg::SEQ_BYTE, "fetch not followed by byte step")

endmodule

[rtl/tagged_bit_stream_packer_top.sv]
// top level of the tagged bit stream packer: csr register, sequencer and byte store
// depends on tbsp_pkg, tbsp_seq and tbsp_store
`timescale 1ns / 1ps

//  channel   ports                        direction  moves
//  req       req_valid/req_ready/payload  in         one command item
//  rsp       rsp_valid/rsp_ready/payload  out        one result item per command
//  csr       csr_wr_en/csr_wr_data        in         use_type_tags, no wait
//
//  one item at a time: accept, decode, fetch the first byte, then read-modify-write
//  each store byte touched through the shared byte unit, then post the result;
//  start, rejected and failed-up-front items skip the fetch and the byte walk
//  the result register frees req_ready while an earlier result waits on rsp_ready
//  synchronous active-high reset clears cursor, limit and control; tags default on

module tagged_bit_stream_packer_top #(
   parameter int CAPACITY_BYTES = tbsp_pkg::DEFAULT_CAPACITY_BYTES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tbsp_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tbsp_pkg::rsp_type rsp_payload,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data
);

   localparam int ADDR_W = $clog2(CAPACITY_BYTES);

   // tag enable register, on after reset
   logic use_type_tags_ff;

   // store port between sequencer and memory
   logic              mem_rd_en;
   logic [ADDR_W-1:0] mem_rd_addr;
   logic [7:0]        mem_rd_data;
   logic              mem_wr_en;
   logic [ADDR_W-1:0] mem_wr_addr;
   logic [7:0]        mem_wr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         use_type_tags_ff <= 1'b1;
      end else if (csr_wr_en) begin
         use_type_tags_ff <= csr_wr_data;
      end
   end

   // sequencer: decode, byte walk, result register
   tbsp_seq #(
      .CAPACITY_BYTES (CAPACITY_BYTES),
      .ADDR_W         (ADDR_W)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .use_type_tags (use_type_tags_ff),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_payload   (rsp_payload),
      .mem_rd_en     (mem_rd_en),
      .mem_rd_addr   (mem_rd_addr),
      .mem_rd_data   (mem_rd_data),
      .mem_wr_en     (mem_wr_en),
      .mem_wr_addr   (mem_wr_addr),
      .mem_wr_data   (mem_wr_data)
   );

   // byte store, contents undefined until written
   tbsp_store #(
      .DEPTH  (CAPACITY_BYTES),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

[dv/tb_tagged_bit_stream_packer_top.sv]
// self-checking testbench for the tagged bit stream packer top level
// depends on tbsp_pkg and tagged_bit_stream_packer_top; a bit-level stream model predicts results
`timescale 1ns / 1ps

module tb_tagged_bit_stream_packer_top;
   import tbsp_pkg::*;

   localparam int STORE_BITS = DEFAULT_CAPACITY_BYTES * 8;

   // bit-level image of the byte store, cursor, limit and tag mode
   class packed_stream_check;
      bit          stream_bits [STORE_BITS];
      bit          written [STORE_BITS];
      int unsigned cursor;
      int unsigned limit;
      bit          tags_on;
      bit          blank_read;
      rsp_type     awaited_results [$];
      int          errors;

      function new();
         cursor = 0;
         limit = 0;
         tags_on = 1'b1;
         errors = 0;
      endfunction

      function void put_bits(int unsigned n, bit [31:0] v);
         int unsigned pos;
         for (int unsigned i = 0; i < n; i++) begin
            pos = cursor + i;
            if (pos < STORE_BITS) begin
               stream_bits[pos] = v[i];
               written[pos] = 1'b1;
            end
         end
         cursor += n;
         if (limit < cursor) limit = cursor;
      endfunction

      // fails without moving when the bits run past the limit
      function bit get_bits(int unsigned n, output bit [31:0] v);
         int unsigned pos;
         v = '0;
         if (cursor + n > limit) return 1'b0;
         for (int unsigned i = 0; i < n; i++) begin
            pos = cursor + i;
            if (pos < STORE_BITS) begin
               v[i] = stream_bits[pos];
               if (!written[pos]) blank_read = 1'b1;
            end
         end
         cursor += n;
         return 1'b1;
      endfunction

      function status_type typed_write(logic [4:0] tag, int unsigned n, bit [31:0] v);
         int unsigned total;
         total = n + (tags_on ? TAG_BITS : 0);
         if (cursor + total > STORE_BITS) return STAT_CAPACITY;
         if (tags_on) put_bits(TAG_BITS, {27'b0, tag});
         put_bits(n, v);
         return STAT_OK;
      endfunction

      // a tag that was read stays consumed even if the value then fails
      function status_type typed_read(logic [4:0] tag, int unsigned n, output bit [31:0] v);
         bit [31:0] seen_tag;
         v = '0;
         if (tags_on) begin
            if (!get_bits(TAG_BITS, seen_tag)) return STAT_PAST_LIMIT;
            if (seen_tag[4:0] != tag) return STAT_TAG_MISMATCH;
         end
         if (!get_bits(n, v)) return STAT_PAST_LIMIT;
         return STAT_OK;
      endfunction

      function rsp_type apply_command(req_type c);
         rsp_type     r;
         int unsigned cnt;
         int unsigned len;
         bit [31:0]   val;
         status_type  st;
         cnt = (c.bit_count > RAW_MAX_BITS) ? 32 : int'(c.bit_count);
         val = '0;
         st = STAT_OK;
         case (c.opcode)
            OP_START: begin
               len = (c.length_bytes > DEFAULT_CAPACITY_BYTES) ?
                     DEFAULT_CAPACITY_BYTES : int'(c.length_bytes);
               cursor = 0;
               limit = len * 8;
            end
            OP_WRITE_RAW: begin
               if (cnt == 0) st = STAT_ZERO_COUNT;
               else if (cursor + cnt > STORE_BITS) st = STAT_CAPACITY;
               else put_bits(cnt, c.write_value);
            end
            OP_READ_RAW: begin
               if (cnt == 0) st = STAT_ZERO_COUNT;
               else if (!get_bits(cnt, val)) st = STAT_PAST_LIMIT;
            end
            OP_WRITE_BOOL: st = typed_write(TAG_BOOL, 1, {31'b0, c.write_value != 0});
            OP_WRITE_S32:  st = typed_write(TAG_S32, 32, c.write_value);
            OP_WRITE_U32:  st = typed_write(TAG_U32, 32, c.write_value);
            OP_READ_BOOL:  st = typed_read(TAG_BOOL, 1, val);
            default:       st = typed_read(TAG_U32, 32, val);
         endcase
         if (st != STAT_OK) val = '0;
         r.status = st;
         r.read_value = val;
         r.used_bytes = 9'((cursor + 7) >> 3);
         r.cursor_bit = 12'(cursor);
         return r;
      endfunction

      // dry run of a read: would it touch a bit that was never written
      function bit reads_unwritten(req_type c);
         int unsigned keep_cursor;
         int unsigned keep_limit;
         rsp_type     dummy;
         if (c.opcode != OP_READ_RAW && c.opcode != OP_READ_BOOL && c.opcode != OP_READ_U32)
            return 1'b0;
         keep_cursor = cursor;
         keep_limit = limit;
         blank_read = 1'b0;
         dummy = apply_command(c);
         cursor = keep_cursor;
         limit = keep_limit;
         return blank_read;
      endfunction

      function void take_command(req_type c);
         awaited_results.push_back(apply_command(c));
      endfunction

      function void compare_result(rsp_type got);
         rsp_type want;
         if (awaited_results.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("%0t: result with no command pending: status %0d value %h",
                        $realtime, got.status, got.read_value);
            return;
         end
         want = awaited_results.pop_front();
         if (got.status !== want.status || got.read_value !== want.read_value ||
             got.used_bytes !== want.used_bytes || got.cursor_bit !== want.cursor_bit) begin
            errors++;
            if (errors <= 10)
               $display({"%0t: mismatch exp status %0d value %h used %0d cursor %0d, ",
                         "got status %0d value %h used %0d cursor %0d"}, $realtime,
                        want.status, want.read_value, want.used_bytes, want.cursor_bit,
                        got.status, got.read_value, got.used_bytes, got.cursor_bit);
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_payload;
   logic    csr_wr_en;
   logic    csr_wr_data;

   packed_stream_check chk = new();
   int sent_items = 0;
   int results_seen = 0;

   tagged_bit_stream_packer_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // run limit, far beyond the slowest legal run
   initial begin
      #600000;
      $display("Simulation FAILED");
      $finish;
   end

   // result monitor: sample at the rising edge, before the block updates
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         chk.compare_result(rsp_payload);
      end
   end

   // receiver: random back-pressure, a quiet window, and two long hold-offs
   // during which the sender keeps offering so the block backs up
   initial begin : rsp_side
      int hold_left;
      int next_hold_at;
      hold_left = 0;
      next_hold_at = 300;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left == 0 && results_seen >= next_hold_at && req_valid) begin
            hold_left = 120;
            next_hold_at += 600;
         end
         if (hold_left != 0) begin
            rsp_ready = 1'b0;
            hold_left--;
         end else if (results_seen >= 600 && results_seen < 760) begin
            rsp_ready = 1'b1;
         end else begin
            rsp_ready = ($urandom_range(99) >= 17);
         end
      end
   end

   function automatic req_type make_cmd(op_type op, int cnt, logic [31:0] v, int len);
      req_type c;
      c.opcode = op;
      c.bit_count = 6'(cnt);
      c.write_value = v;
      c.length_bytes = 9'(len);
      return c;
   endfunction

   function automatic req_type random_cmd();
      req_type c;
      c.opcode = op_type'($urandom_range(7));
      c.bit_count = 6'($urandom_range(63));
      c.write_value = $urandom;
      c.length_bytes = 9'($urandom_range(511));
      return c;
   endfunction

   // present one item at the falling edge and hold it until accepted
   task automatic offer_command(input req_type cmd);
      // never read store bits that hold no written value
      if (chk.reads_unwritten(cmd)) cmd.opcode = OP_WRITE_RAW;
      if ($urandom_range(99) < 17 && !(sent_items >= 600 && sent_items < 760)) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_payload = cmd;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      chk.take_command(cmd);
      sent_items++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // tag mode only changes with the block drained and idle
   task automatic switch_tags(input bit on);
      while (chk.awaited_results.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_wr_data = on;
      @(negedge clock);
      csr_wr_en = 1'b0;
      chk.tags_on = on;
   endtask

   initial begin : stimulus
      req_type     written_q [$];
      req_type     cmd;
      int          len;
      int          span;

      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty stream, zero counts, every write type, then read back
      // with tag mismatches and a value that fails after its tag was consumed
      offer_command(make_cmd(OP_READ_RAW, 5, 32'h0, 0));
      offer_command(make_cmd(OP_READ_BOOL, 0, 32'h0, 0));
      offer_command(make_cmd(OP_WRITE_RAW, 0, 32'hFFFF_FFFF, 0));
      offer_command(make_cmd(OP_READ_RAW, 0, 32'h0, 0));
      offer_command(make_cmd(OP_WRITE_RAW, 32, 32'hFFFF_FFFF, 0));
      offer_command(make_cmd(OP_WRITE_RAW, 63, 32'h0, 0));
      offer_command(make_cmd(OP_WRITE_BOOL, 0, 32'h8000_0000, 0));
      offer_command(make_cmd(OP_WRITE_BOOL, 0, 32'h0, 0));
      offer_command(make_cmd(OP_WRITE_S32, 0, 32'h8000_0000, 0));
      offer_command(make_cmd(OP_WRITE_U32, 0, 32'h7FFF_FFFF, 0));
      offer_command(make_cmd(OP_WRITE_RAW, 1, 32'hFFFF_FFFE, 0));
      offer_command(make_cmd(OP_START, 0, 32'h0, 511));
      offer_command(make_cmd(OP_START, 0, 32'h0, 18));
      offer_command(make_cmd(OP_READ_RAW, 32, 32'h0, 0));
      offer_command(make_cmd(OP_READ_RAW, 40, 32'h0, 0));
      offer_command(make_cmd(OP_READ_BOOL, 0, 32'h0, 0));
      offer_command(make_cmd(OP_READ_U32, 0, 32'h0, 0));
      offer_command(make_cmd(OP_READ_RAW, 1, 32'h0, 0));
      offer_command(make_cmd(OP_READ_U32, 0, 32'h0, 0));
      offer_command(make_cmd(OP_READ_RAW, 32, 32'h0, 0));
      offer_command(make_cmd(OP_READ_U32, 0, 32'h0, 0));
      offer_command(make_cmd(OP_READ_RAW, 63, 32'h0, 0));

      // untagged fill of the whole store up to capacity, then writes that overflow
      switch_tags(1'b0);
      offer_command(make_cmd(OP_START, 0, 32'h0, 0));
      while (chk.cursor < STORE_BITS) begin
         span = $urandom_range(1, 32);
         if (span > STORE_BITS - chk.cursor) span = STORE_BITS - chk.cursor;
         offer_command(make_cmd(OP_WRITE_RAW, span, $urandom, 0));
      end
      offer_command(make_cmd(OP_WRITE_BOOL, 0, 32'h1, 0));
      offer_command(make_cmd(OP_WRITE_S32, 0, $urandom, 0));
      offer_command(make_cmd(OP_WRITE_U32, 0, $urandom, 0));
      offer_command(make_cmd(OP_WRITE_RAW, 1, 32'h1, 0));

      // tagged overflow near the end, then random reads with the limit set to the full store
      switch_tags(1'b1);
      offer_command(make_cmd(OP_WRITE_BOOL, 0, 32'h1, 0));
      offer_command(make_cmd(OP_START, 0, 32'h0, 300));
      repeat (120) begin
         cmd = random_cmd();
         case ($urandom_range(2))
            0:       cmd.opcode = OP_READ_RAW;
            1:       cmd.opcode = OP_READ_BOOL;
            default: cmd.opcode = OP_READ_U32;
         endcase
         offer_command(cmd);
      end

      // random rounds: a run of writes, rewind to the written length, read the
      // run back with matching reads, with noise mixed in
      while (sent_items < 1100) begin
         if ($urandom_range(2) == 0) switch_tags($urandom_range(1));
         if ($urandom_range(4) != 0)
            offer_command(make_cmd(OP_START, 0, $urandom, $urandom_range(8)));
         written_q.delete();
         repeat ($urandom_range(2, 12)) begin
            cmd = random_cmd();
            case ($urandom_range(3))
               0:       cmd.opcode = OP_WRITE_RAW;
               1:       cmd.opcode = OP_WRITE_BOOL;
               2:       cmd.opcode = OP_WRITE_S32;
               default: cmd.opcode = OP_WRITE_U32;
            endcase
            if (cmd.opcode == OP_WRITE_BOOL && $urandom_range(1) == 0) cmd.write_value = '0;
            written_q.push_back(cmd);
            offer_command(cmd);
         end

         len = int'((chk.cursor + 7) / 8);
         if ($urandom_range(9) < 3) len = len + $urandom_range(2) - 1;
         if (len < 0) len = 0;
         offer_command(make_cmd(OP_START, $urandom_range(63), $urandom, len));

         foreach (written_q[i]) begin
            cmd = random_cmd();
            case (written_q[i].opcode)
               OP_WRITE_RAW:  cmd.opcode = OP_READ_RAW;
               OP_WRITE_BOOL: cmd.opcode = OP_READ_BOOL;
               default:       cmd.opcode = OP_READ_U32;
            endcase
            if ($urandom_range(9) != 0) cmd.bit_count = written_q[i].bit_count;
            if ($urandom_range(9) == 0) cmd = random_cmd();
            offer_command(cmd);
         end

         repeat ($urandom_range(3)) offer_command(random_cmd());
      end

      // drain, then allow the block's latency to pass
      req_valid = 1'b0;
      while (chk.awaited_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (chk.errors == 0 && chk.awaited_results.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl
rtl/tbsp_pkg.sv
rtl/tbsp_store.sv
rtl/tbsp_lane.sv
rtl/tbsp_seq.sv
rtl/tagged_bit_stream_packer_top.sv
dv/tb_tagged_bit_stream_packer_top.sv
